// ===== design/wssm_pkg.sv =====
// Shared types, constants and search helpers for the star-segment matcher.
`default_nettype none
package wssm_pkg;

  // Mask geometry: four 64-bit mask registers hold 32 mask bytes
  localparam int MASK_BYTES = 32;
  localparam int IDX_W      = $clog2(MASK_BYTES + 1);
  localparam int MASK_W     = MASK_BYTES * 8;
  localparam int REG_W      = 64;
  localparam int ADDR_W     = 6;

  // Default maximum text length
  localparam longint unsigned TEXT_MAX_DEF = 64'd65535;

  // Separator byte
  localparam logic [7:0] STAR_CHAR = 8'h2a;

  // Register indexes (byte address is 8 * index)
  localparam logic [2:0] REG_MASK_LENGTH = 3'd0;
  localparam logic [2:0] REG_MASK_LOW    = 3'd1;
  localparam logic [2:0] REG_MASK_SECOND = 3'd2;
  localparam logic [2:0] REG_MASK_THIRD  = 3'd3;
  localparam logic [2:0] REG_MASK_HIGH   = 3'd4;

  // Item commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  // Input item
  typedef struct packed {
    logic       command;
    logic [7:0] text_byte;
  } item_t;

  // Result item
  typedef struct packed {
    logic        matched;
    logic [15:0] match_start;
    logic [15:0] match_end;
    logic [16:0] match_length;
    logic        too_long;
  } res_t;

  // Configuration view handed from the register block to the matcher
  typedef struct packed {
    idx_t                  mask_len;  // saturated to MASK_BYTES
    logic [MASK_W-1:0]     mask;
    logic [MASK_BYTES-1:0] star;      // one bit per mask byte that is '*'
    logic                  rearm;     // register write this cycle
  } cfg_t;

  // First index i in [from, lim) with vec[i] set, else lim (priority encoder)
  function automatic idx_t find_first(logic [MASK_BYTES-1:0] vec, idx_t from, idx_t lim);
    idx_t res;
    res = lim;
    for (int i = MASK_BYTES - 1; i >= 0; i--) begin
      if (vec[i] && (IDX_W'(i) >= from) && (IDX_W'(i) < lim)) begin
        res = IDX_W'(i);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== design/wssm_cfg.sv =====
// APB register block: mask length and mask bytes, star map, rearm strobe.
`default_nettype none
module wssm_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wssm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [wssm_pkg::REG_W-1:0]   pwdata,
  output logic      [wssm_pkg::REG_W-1:0]   prdata,
  output logic                              pready,
  output wssm_pkg::cfg_t                    cfg
);

  logic [5:0]                  mask_length;
  logic [wssm_pkg::MASK_W-1:0] mask;
  logic [2:0]                  index;
  logic                        wr;

  assign index  = paddr[wssm_pkg::ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_length <= '0;
      mask        <= '0;
    end else if (wr) begin
      unique case (index)
        wssm_pkg::REG_MASK_LENGTH: mask_length     <= pwdata[5:0];
        wssm_pkg::REG_MASK_LOW:    mask[0   +: 64] <= pwdata;
        wssm_pkg::REG_MASK_SECOND: mask[64  +: 64] <= pwdata;
        wssm_pkg::REG_MASK_THIRD:  mask[128 +: 64] <= pwdata;
        wssm_pkg::REG_MASK_HIGH:   mask[192 +: 64] <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (index)
      wssm_pkg::REG_MASK_LENGTH: prdata = 64'(mask_length);
      wssm_pkg::REG_MASK_LOW:    prdata = mask[0   +: 64];
      wssm_pkg::REG_MASK_SECOND: prdata = mask[64  +: 64];
      wssm_pkg::REG_MASK_THIRD:  prdata = mask[128 +: 64];
      wssm_pkg::REG_MASK_HIGH:   prdata = mask[192 +: 64];
      default:                   prdata = '0;
    endcase
  end

  // Matcher view: saturated length, star map, rearm on any known register
  always_comb begin
    cfg.mask = mask;
    if (mask_length > 6'(wssm_pkg::MASK_BYTES)) begin
      cfg.mask_len = wssm_pkg::IDX_W'(wssm_pkg::MASK_BYTES);
    end else begin
      cfg.mask_len = wssm_pkg::IDX_W'(mask_length);
    end
    for (int i = 0; i < wssm_pkg::MASK_BYTES; i++) begin
      cfg.star[i] = (mask[8*i +: 8] == wssm_pkg::STAR_CHAR);
    end
    cfg.rearm = wr && (index <= wssm_pkg::REG_MASK_HIGH);
  end

endmodule
`default_nettype wire

// ===== design/wssm_core.sv =====
// Matcher: byte window, segment compare, match state and end-of-text report.
`default_nettype none
module wssm_core #(
  parameter longint unsigned TEXT_MAX = wssm_pkg::TEXT_MAX_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire wssm_pkg::cfg_t cfg,
  input  wire logic           take,   // item accepted this cycle
  input  wire wssm_pkg::item_t item,
  output wssm_pkg::res_t      res     // report for an end-of-text item
);

  localparam int POS_W = $clog2(TEXT_MAX + 1);
  localparam int MB    = wssm_pkg::MASK_BYTES;
  localparam int MW    = wssm_pkg::MASK_W;
  localparam int IW    = wssm_pkg::IDX_W;

  // State
  logic [MW-1:0]     recent;       // byte j = j-th most recent text byte
  logic [POS_W-1:0]  pos;
  wssm_pkg::idx_t    offset;       // current segment start (when !at_start)
  logic              at_start;     // current segment is the first one
  logic [IW-1:0]     bsince;       // bytes since last segment, saturating
  logic              first_found;
  logic [POS_W-1:0]  first_pos;
  logic [POS_W-1:0]  last_end;
  logic              overflowed;

  logic [MW-1:0]     recent_next;
  logic [POS_W-1:0]  pos_next;
  wssm_pkg::idx_t    offset_next;
  logic              at_start_next;
  logic [IW-1:0]     bsince_next;
  logic              first_found_next;
  logic [POS_W-1:0]  first_pos_next;
  logic [POS_W-1:0]  last_end_next;
  logic              overflowed_next;

  // Segment search
  wssm_pkg::idx_t    n;
  wssm_pkg::idx_t    first_off;
  wssm_pkg::idx_t    cur_off;
  wssm_pkg::idx_t    send;
  wssm_pkg::idx_t    len;
  wssm_pkg::idx_t    next_off;
  wssm_pkg::idx_t    shamt;
  logic [MW-1:0]     window;
  logic [MW-1:0]     rev;
  logic [MW-1:0]     aligned;
  logic [MB-1:0]     eq;
  logic [IW-1:0]     bsince_inc;
  logic [POS_W-1:0]  pos_inc;
  logic              hit;

  assign n         = cfg.mask_len;
  assign first_off = wssm_pkg::find_first(~cfg.star, '0, n);
  assign cur_off   = at_start ? first_off : offset;
  assign send      = wssm_pkg::find_first(cfg.star, cur_off, n);
  assign len       = send - cur_off;
  assign next_off  = wssm_pkg::find_first(~cfg.star, send, n);
  assign pos_inc   = pos + 1'b1;
  assign bsince_inc = (bsince == '1) ? bsince : bsince + 1'b1;

  // Window after shifting in the new byte, reversed and aligned so that
  // byte i lines up with mask byte i of the segment ending at send
  always_comb begin
    window = {recent[MW-9:0], item.text_byte};
    for (int j = 0; j < MB; j++) begin
      rev[8*j +: 8] = window[8*(MB-1-j) +: 8];
    end
    shamt   = IW'(MB) - send;
    aligned = rev >> {shamt, 3'b000};
    for (int i = 0; i < MB; i++) begin
      eq[i] = (cfg.mask[8*i +: 8] == aligned[8*i +: 8]) ||
              !((IW'(i) >= cur_off) && (IW'(i) < send));
    end
    hit = (cur_off < n) && (len != '0) && (bsince_inc >= len) && (&eq);
  end

  // Next state
  always_comb begin
    recent_next      = recent;
    pos_next         = pos;
    offset_next      = offset;
    at_start_next    = at_start;
    bsince_next      = bsince;
    first_found_next = first_found;
    first_pos_next   = first_pos;
    last_end_next    = last_end;
    overflowed_next  = overflowed;
    if (cfg.rearm || (take && (item.command == wssm_pkg::CMD_END))) begin
      pos_next         = '0;
      at_start_next    = 1'b1;
      bsince_next      = '0;
      first_found_next = 1'b0;
      first_pos_next   = '0;
      last_end_next    = '0;
      overflowed_next  = 1'b0;
    end else if (take) begin
      if (pos >= POS_W'(TEXT_MAX)) begin
        overflowed_next = 1'b1;
      end else begin
        recent_next = window;
        pos_next    = pos_inc;
        bsince_next = hit ? '0 : bsince_inc;
        if (hit) begin
          if (!first_found) begin
            first_found_next = 1'b1;
            first_pos_next   = pos_inc - POS_W'(len);
          end
          last_end_next = pos_inc;
          offset_next   = next_off;
          at_start_next = 1'b0;
        end
      end
    end
  end

  // Control state and text position are reset; window, segment offset and match positions are payload
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      at_start    <= 1'b1;
      bsince      <= '0;
      first_found <= 1'b0;
      overflowed  <= 1'b0;
    end else begin
      pos         <= pos_next;
      at_start    <= at_start_next;
      bsince      <= bsince_next;
      first_found <= first_found_next;
      overflowed  <= overflowed_next;
    end
  end

  always_ff @(posedge clk) begin
    recent    <= recent_next;
    offset    <= offset_next;
    first_pos <= first_pos_next;
    last_end  <= last_end_next;
  end

  // End-of-text report from the current state
  logic [POS_W-1:0] s_sel;
  logic [POS_W-1:0] e_sel;
  logic [63:0]      s_ext;
  logic [63:0]      e_ext;

  always_comb begin
    s_sel = first_found ? first_pos : '0;
    e_sel = first_found ? last_end : pos;
    s_ext = 64'(s_sel);
    e_ext = 64'(e_sel);
    res   = '0;
    if (overflowed) begin
      res.too_long = 1'b1;
    end else if (n == '0) begin
      res.matched = (pos == '0);
    end else if ((pos != '0) && (cur_off >= n)) begin
      res.matched      = 1'b1;
      res.match_start  = s_ext[15:0];
      res.match_end    = e_ext[15:0];
      res.match_length = e_ext[16:0] - s_ext[16:0] + 17'd1;
    end
  end

endmodule
`default_nettype wire

// ===== design/wssm_out.sv =====
// Result register with a skid stage so input keeps flowing while one report waits.
`default_nettype none
module wssm_out (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire wssm_pkg::res_t push_data,
  output logic                ready,
  output logic                result_valid,
  input  wire logic           result_ready,
  output wssm_pkg::res_t      result
);

  logic           skid_valid;
  wssm_pkg::res_t skid_data;
  logic           pop;

  assign pop   = result_valid && result_ready;
  assign ready = !skid_valid;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (result_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (pop) begin
      result_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        result <= skid_data;
      end
    end else if (push) begin
      if (result_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        result <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/wildcard_star_segment_match_unit.sv =====
// Top level of the star-segment wildcard matcher.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_ready      wssm_pkg::item_t
//   result    out        result_valid / result_ready  wssm_pkg::res_t
//   config    in         APB psel/penable/pwrite      64-bit registers at 8*index
//
// One item per cycle while item_ready is high: a text byte is compared against
// the current segment in the cycle it is accepted and updates the match state at
// that edge. An end-of-text report is registered at its accepting edge.
// Reset (rst, synchronous) clears the mask and rearms; no clearing pass.
// A two-entry result buffer keeps item_ready high while one report waits;
// item_ready drops only while a second report is held.
`default_nettype none
module wildcard_star_segment_match_unit #(
  parameter longint unsigned TEXT_MAX = wssm_pkg::TEXT_MAX_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_ready,
  input  wire wssm_pkg::item_t              item,
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output wssm_pkg::res_t                    result,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wssm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [wssm_pkg::REG_W-1:0]   pwdata,
  output logic      [wssm_pkg::REG_W-1:0]   prdata,
  output logic                              pready
);

  wssm_pkg::cfg_t cfg;
  wssm_pkg::res_t report;
  logic           take;
  logic           push;

  assign take = item_valid && item_ready;
  assign push = take && (item.command == wssm_pkg::CMD_END);

  wssm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wssm_core #(
    .TEXT_MAX (TEXT_MAX)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (take),
    .item (item),
    .res  (report)
  );

  wssm_out u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (report),
    .ready        (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTHESIS
  // Input stalls only when a report is already waiting at the output
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid)
    else $error("item_ready low with no pending result");

  // A report pushed under output stall fills the skid stage
  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (push && result_valid && !result_ready) |=> !item_ready)
    else $error("stalled report not held in skid stage");

  // Overflow never reports a match
  a_too_long_fails: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.too_long) |-> !result.matched)
    else $error("too_long with matched set");

  // Positions are zero when not matched
  a_unmatched_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.matched) |->
      (result.match_start == 16'd0 && result.match_end == 16'd0 &&
       result.match_length == 17'd0))
    else $error("nonzero positions on a failed match");
`endif

endmodule
`default_nettype wire
